// ===== src/clrs_pkg.sv =====
package clrs_pkg;

    localparam int VALUE_W   = 32;
    localparam int EXT_W     = VALUE_W + 1;
    localparam int DIFF_W    = VALUE_W + 2;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int DIV_STEPS = VALUE_W;
    localparam int CFG_IDX_W = 3;

    // 100.0 in Q16.16
    localparam logic [VALUE_W-1:0] RANGE_HIGH_RESET = VALUE_W'(6553600);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_LOW     = 3'd0,
        CFG_INPUT_HIGH    = 3'd1,
        CFG_OUTPUT_LOW    = 3'd2,
        CFG_OUTPUT_HIGH   = 3'd3,
        CFG_OFFSET_ENABLE = 3'd4,
        CFG_ORIGIN_OFFSET = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_SPAN = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic                      in_range;
        logic                      degen;
        logic                      tneg;
        logic signed [VALUE_W-1:0] tlo;
        logic signed [VALUE_W-1:0] clamp;
        logic signed [VALUE_W-1:0] org_add;
    } t_side;

endpackage

// ===== src/clamped_linear_range_scaler_unit.sv =====
// Clamped linear range scaler. Maps a signed Q16.16 sample from the input range onto the
// output range (func 0) or back (func 1), clamping outside the range, applying the optional
// origin offset, and saturating to 32 bits. One transaction is accepted per cycle unless the
// pipeline holds. Each result passes through four setup stages (source/target select,
// differences, magnitudes, 32x32 multiply), a 32-stage restoring divider that resolves one
// quotient bit per stage, a combine stage and the output register. A skid register behind
// the output lets one further result land while the output waits; the whole pipeline holds
// only when both are full. Registers take effect for items accepted after the write and are
// to be written while no transaction is in flight.
module clamped_linear_range_scaler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [clrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [clrs_pkg::VALUE_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic signed [clrs_pkg::VALUE_W-1:0] i_sample_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [clrs_pkg::VALUE_W-1:0] o_mapped_value,
    output logic [1:0]                          o_status
);

    localparam int VW = clrs_pkg::VALUE_W;
    localparam int EW = clrs_pkg::EXT_W;
    localparam int DW = clrs_pkg::DIFF_W;
    localparam int PW = clrs_pkg::PROD_W;

    // Configuration registers
    logic signed [VW-1:0] r_in_lo, r_in_hi, r_out_lo, r_out_hi, r_origin;
    logic                 r_off_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_lo  <= '0;
            r_in_hi  <= clrs_pkg::RANGE_HIGH_RESET;
            r_out_lo <= '0;
            r_out_hi <= clrs_pkg::RANGE_HIGH_RESET;
            r_off_en <= 1'b0;
            r_origin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clrs_pkg::CFG_INPUT_LOW:     r_in_lo  <= i_cfg_data;
                clrs_pkg::CFG_INPUT_HIGH:    r_in_hi  <= i_cfg_data;
                clrs_pkg::CFG_OUTPUT_LOW:    r_out_lo <= i_cfg_data;
                clrs_pkg::CFG_OUTPUT_HIGH:   r_out_hi <= i_cfg_data;
                clrs_pkg::CFG_OFFSET_ENABLE: r_off_en <= i_cfg_data[0];
                clrs_pkg::CFG_ORIGIN_OFFSET: r_origin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;

    // Stage 1: pick source and target, take the offset off an inverse sample
    logic                 r1_valid;
    logic signed [EW-1:0] r1_x;
    logic signed [VW-1:0] r1_slo, r1_shi, r1_tlo, r1_thi, r1_org_add;
    logic signed [VW-1:0] w_org_eff;
    logic signed [EW-1:0] n1_x;

    always_comb begin
        w_org_eff = r_off_en ? r_origin : '0;
        if (i_func) begin
            n1_x = $signed({i_sample_value[VW-1], i_sample_value})
                 - $signed({w_org_eff[VW-1], w_org_eff});
        end else begin
            n1_x = $signed({i_sample_value[VW-1], i_sample_value});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x       <= n1_x;
            r1_slo     <= i_func ? r_out_lo : r_in_lo;
            r1_shi     <= i_func ? r_out_hi : r_in_hi;
            r1_tlo     <= i_func ? r_in_lo  : r_out_lo;
            r1_thi     <= i_func ? r_in_hi  : r_out_hi;
            r1_org_add <= i_func ? '0 : w_org_eff;
        end
    end

    // Stage 2: differences, range test and clamp choice
    logic                 r2_valid;
    logic signed [DW-1:0] r2_dxs;
    logic signed [EW-1:0] r2_dspan;
    logic signed [EW-1:0] r2_dt;
    clrs_pkg::t_side      r2_side;

    logic signed [EW-1:0] w_slo_e, w_shi_e, w_tlo_e, w_thi_e;
    logic signed [DW-1:0] n2_dxs;
    logic signed [EW-1:0] n2_dspan, n2_dt;
    clrs_pkg::t_side      n2_side;

    always_comb begin
        w_slo_e  = $signed({r1_slo[VW-1], r1_slo});
        w_shi_e  = $signed({r1_shi[VW-1], r1_shi});
        w_tlo_e  = $signed({r1_tlo[VW-1], r1_tlo});
        w_thi_e  = $signed({r1_thi[VW-1], r1_thi});
        n2_dxs   = $signed({r1_x[EW-1], r1_x}) - $signed({w_slo_e[EW-1], w_slo_e});
        n2_dspan = w_shi_e - w_slo_e;
        n2_dt    = w_thi_e - w_tlo_e;

        n2_side.in_range = ((r1_x >= w_slo_e) && (r1_x <= w_shi_e))
                        || ((r1_x <= w_slo_e) && (r1_x >= w_shi_e));
        n2_side.degen    = (r1_slo == r1_shi);
        n2_side.tneg     = n2_dt[EW-1];
        n2_side.tlo      = r1_tlo;
        n2_side.org_add  = r1_org_add;
        // Outside the range: snap to the target end of the nearer source end
        if (r1_slo < r1_shi) begin
            n2_side.clamp = (r1_x > w_shi_e) ? r1_thi : r1_tlo;
        end else begin
            n2_side.clamp = (r1_x < w_shi_e) ? r1_thi : r1_tlo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dxs   <= n2_dxs;
            r2_dspan <= n2_dspan;
            r2_dt    <= n2_dt;
            r2_side  <= n2_side;
        end
    end

    // Stage 3: magnitudes; each fits the value width wherever it is used
    logic                 r3_valid;
    logic [VW-1:0]        r3_a, r3_b, r3_d;
    clrs_pkg::t_side      r3_side;
    logic [DW-1:0]        w_abs_xs;
    logic [EW-1:0]        w_abs_span, w_abs_t;

    always_comb begin
        w_abs_xs   = r2_dxs[DW-1]   ? DW'(-r2_dxs)   : DW'(r2_dxs);
        w_abs_span = r2_dspan[EW-1] ? EW'(-r2_dspan) : EW'(r2_dspan);
        w_abs_t    = r2_dt[EW-1]    ? EW'(-r2_dt)    : EW'(r2_dt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a    <= w_abs_xs[VW-1:0];
            r3_b    <= w_abs_t[VW-1:0];
            r3_d    <= w_abs_span[VW-1:0];
            r3_side <= r2_side;
        end
    end

    // Stage 4: offset times target span
    logic                 r4_valid;
    logic [PW-1:0]        r4_p;
    logic [VW-1:0]        r4_d;
    clrs_pkg::t_side      r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_p    <= PW'(r3_a) * PW'(r3_b);
            r4_d    <= r3_d;
            r4_side <= r3_side;
        end
    end

    // Divide by the source span
    logic                 w_dv_valid;
    logic [VW-1:0]        w_dv_quo;
    clrs_pkg::t_side      w_dv_side;

    clrs_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_valid),
        .i_num   (r4_p),
        .i_den   (r4_d),
        .i_side  (r4_side),
        .o_valid (w_dv_valid),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // Stage 5: step from the low target end towards the high one, or take the clamp
    logic                 r5_valid;
    logic signed [EW-1:0] r5_val;
    logic                 r5_degen;
    logic signed [VW-1:0] r5_org_add;
    logic signed [EW-1:0] w_tlo5, w_q5, n5_val;

    always_comb begin
        w_tlo5 = $signed({w_dv_side.tlo[VW-1], w_dv_side.tlo});
        w_q5   = $signed({1'b0, w_dv_quo});
        if (!w_dv_side.in_range) begin
            n5_val = $signed({w_dv_side.clamp[VW-1], w_dv_side.clamp});
        end else if (w_dv_side.tneg) begin
            n5_val = w_tlo5 - w_q5;
        end else begin
            n5_val = w_tlo5 + w_q5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_val     <= n5_val;
            r5_degen   <= w_dv_side.degen;
            r5_org_add <= w_dv_side.org_add;
        end
    end

    // Offset add, zero-span check and saturation, straight into the output or skid register
    logic signed [DW-1:0] w_sum;
    logic                 w_sat;
    logic signed [VW-1:0] w_fin_value;
    logic [1:0]           w_fin_status;

    always_comb begin
        w_sum = $signed({{2{r5_org_add[VW-1]}}, r5_org_add})
              + $signed({r5_val[EW-1], r5_val});
        w_sat = !((&w_sum[DW-1:VW-1]) || !(|w_sum[DW-1:VW-1]));
        if (r5_degen) begin
            w_fin_value  = '0;
            w_fin_status = clrs_pkg::ST_ZERO_SPAN;
        end else if (w_sat) begin
            w_fin_value  = w_sum[DW-1] ? $signed({1'b1, {(VW-1){1'b0}}})
                                       : $signed({1'b0, {(VW-1){1'b1}}});
            w_fin_status = clrs_pkg::ST_SATURATED;
        end else begin
            w_fin_value  = w_sum[VW-1:0];
            w_fin_status = clrs_pkg::ST_OK;
        end
    end

    // Output register with skid: pipeline holds only while the skid is occupied
    logic                 r_out_valid, r_skid_valid;
    logic signed [VW-1:0] r_out_value, r_skid_value;
    logic [1:0]           r_out_status, r_skid_status;
    logic                 w_out_free;

    assign w_en       = !r_skid_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_valid <= r5_valid;
        end else if (r5_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_free) begin
                r_out_value  <= r_skid_value;
                r_out_status <= r_skid_status;
            end
        end else if (w_out_free) begin
            r_out_value  <= w_fin_value;
            r_out_status <= w_fin_status;
        end else begin
            r_skid_value  <= w_fin_value;
            r_skid_status <= w_fin_status;
        end
    end

    assign o_in_ready     = w_en;
    assign o_out_valid    = r_out_valid;
    assign o_mapped_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

// ===== src/clrs_div_pipe.sv =====
module clrs_div_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [clrs_pkg::PROD_W-1:0]         i_num,
    input  logic [clrs_pkg::VALUE_W-1:0]        i_den,
    input  clrs_pkg::t_side                     i_side,
    output logic                                o_valid,
    output logic [clrs_pkg::VALUE_W-1:0]        o_quo,
    output clrs_pkg::t_side                     o_side
);

    localparam int VW = clrs_pkg::VALUE_W;
    localparam int DS = clrs_pkg::DIV_STEPS;

    logic [DS-1:0]   r_valid;
    logic [VW-1:0]   r_rem  [DS];
    logic [VW-1:0]   r_num  [DS];
    logic [VW-1:0]   r_quo  [DS];
    logic [VW-1:0]   r_den  [DS];
    clrs_pkg::t_side r_side [DS];

    logic [VW-1:0]   s_rem  [DS];
    logic [VW-1:0]   s_num  [DS];
    logic [VW-1:0]   s_quo  [DS];
    logic [VW-1:0]   s_den  [DS];
    clrs_pkg::t_side s_side [DS];

    logic [VW:0]     w_trial [DS];
    logic [VW:0]     w_diff  [DS];
    logic [DS-1:0]   w_ge;

    logic [VW-1:0]   n_rem  [DS];
    logic [VW-1:0]   n_num  [DS];
    logic [VW-1:0]   n_quo  [DS];

    // Stage inputs: first stage takes the product, the rest chain
    always_comb begin
        s_rem[0]  = i_num[clrs_pkg::PROD_W-1:VW];
        s_num[0]  = i_num[VW-1:0];
        s_quo[0]  = '0;
        s_den[0]  = i_den;
        s_side[0] = i_side;
        for (int k = 1; k < DS; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_num[k]  = r_num[k-1];
            s_quo[k]  = r_quo[k-1];
            s_den[k]  = r_den[k-1];
            s_side[k] = r_side[k-1];
        end
    end

    // One restoring step per stage: shift in the next numerator bit, trial subtract
    always_comb begin
        for (int k = 0; k < DS; k++) begin
            w_trial[k] = {s_rem[k], s_num[k][VW-1]};
            w_diff[k]  = w_trial[k] - {1'b0, s_den[k]};
            w_ge[k]    = (w_trial[k] >= {1'b0, s_den[k]});
            n_rem[k]   = w_ge[k] ? w_diff[k][VW-1:0] : w_trial[k][VW-1:0];
            n_num[k]   = {s_num[k][VW-2:0], 1'b0};
            n_quo[k]   = {s_quo[k][VW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= s_den[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_valid[DS-1];
    assign o_quo   = r_quo[DS-1];
    assign o_side  = r_side[DS-1];

endmodule
